>>> design/tcw_pkg.sv
// Shared types and constants of the text console writer.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package tcw_pkg;

   // Port field widths.
   localparam int ADDR_W = 11;
   localparam int CELL_W = 16;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [7:0]        byte_type;

   // Request function codes.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // Character codes with a special meaning.
   localparam byte_type CH_BS    = 8'h08;
   localparam byte_type CH_LF    = 8'h0A;
   localparam byte_type CH_CR    = 8'h0D;
   localparam byte_type CH_SPACE = 8'h20;

   // Attribute used when a request carries a zero attribute, and the blank cell.
   localparam byte_type DEFAULT_ATTR = 8'h07;
   localparam cell_type BLANK_CELL   = 16'h0720;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_step;
      logic load_req;
      logic exec_write;
      logic scroll_step;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_read;
      logic need_scroll;
      logic clr_last;
      logic scroll_last;
   } status_type;

endpackage

`default_nettype wire

>>> design/text_console_writer.sv
// Character-cell text console with a ROWS x COLS screen store and a cursor.
// Instantiates tcw_controller and tcw_datapath; depends on tcw_pkg.
//
// After reset the block blanks the store with a clearing pass over all ROWS*COLS
// cells, during which req_ready stays low. A request is then handled one at
// a time: a read, or a write that does not pass the last cell, is accepted,
// executed through the store, and its result is loaded into the response
// register once that register is free. A write that passes the last cell
// scrolls the screen by rotating the row offset and blanking one row through
// the store's write port before the response is loaded. The response register
// lets a new request enter while the previous response still waits.
`default_nettype none

module text_console_writer #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_func,
   input  wire tcw_pkg::cell_type req_char_code,
   input  wire tcw_pkg::addr_type req_cell_addr,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tcw_pkg::addr_type      rsp_cursor_pos,
   output tcw_pkg::cell_type      rsp_cell_value
);

   tcw_pkg::cmd_type    cmd;
   tcw_pkg::status_type status;

   tcw_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_cell_addr  (req_cell_addr),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_value (rsp_cell_value)
   );

endmodule

`default_nettype wire

>>> design/tcw_datapath.sv
// Datapath of the text console writer: screen store, cursor, row rotation and
// response register. Depends on tcw_pkg; driven by tcw_controller commands.
`default_nettype none

module tcw_datapath #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tcw_pkg::cmd_type   cmd,
   output tcw_pkg::status_type     status,
   input  wire logic               req_func,
   input  wire tcw_pkg::cell_type  req_char_code,
   input  wire tcw_pkg::addr_type  req_cell_addr,
   output tcw_pkg::addr_type       rsp_cursor_pos,
   output tcw_pkg::cell_type       rsp_cell_value
);

   localparam int SIZE = ROWS * COLS;
   localparam int AW   = $clog2(SIZE);
   localparam int CW   = $clog2(SIZE + COLS);
   localparam int COLW = $clog2(COLS);
   localparam logic [AW:0] SIZE_X = (AW + 1)'(SIZE);
   localparam logic [AW:0] COLS_X = (AW + 1)'(COLS);

   // Latched request.
   logic              req_func_ff;
   tcw_pkg::cell_type req_code_ff;
   tcw_pkg::addr_type req_addr_ff;

   // Cursor as a linear index plus its column, and the physical offset of row 0.
   logic [CW-1:0]   cursor_ff;
   logic [COLW-1:0] col_ff;
   logic [AW-1:0]   top_off_ff;
   logic [AW-1:0]   clr_cnt_ff;
   logic [COLW-1:0] scr_cnt_ff;

   // Screen store with registered read data.
   tcw_pkg::cell_type mem [SIZE];
   tcw_pkg::cell_type rd_data_ff;
   logic              in_range_ff;

   tcw_pkg::addr_type rsp_cursor_ff;
   tcw_pkg::cell_type rsp_cell_ff;

   tcw_pkg::byte_type attr;
   tcw_pkg::byte_type ch;
   logic [CW-1:0]     cur_nx;
   logic [CW-1:0]     cur_fin;
   logic [COLW-1:0]   col_nx;
   logic              wr_hit;
   logic [AW-1:0]     wr_log;
   tcw_pkg::cell_type wr_cell;
   logic              need_scroll;
   logic [AW:0]       wr_sum;
   logic [AW-1:0]     wr_phys;
   logic [AW-1:0]     rd_log;
   logic [AW:0]       rd_sum;
   logic [AW-1:0]     rd_phys;
   logic              rd_in_range;
   logic [AW-1:0]     scr_addr;
   logic [AW:0]       top_sum;
   logic [AW-1:0]     top_nx;
   logic              we;
   logic [AW-1:0]     wa;
   tcw_pkg::cell_type wd;

   // A zero attribute is replaced by the default one.
   assign attr = (req_code_ff[15:8] == 8'h00) ? tcw_pkg::DEFAULT_ATTR : req_code_ff[15:8];
   assign ch   = req_code_ff[7:0];

   // Cursor movement and the cell that a write request stores.
   always_comb begin
      cur_nx  = cursor_ff;
      col_nx  = col_ff;
      wr_hit  = 1'b0;
      wr_log  = AW'(cursor_ff);
      wr_cell = {attr, ch};
      unique case (ch)
         tcw_pkg::CH_BS: begin
            if (cursor_ff != '0) begin
               cur_nx  = cursor_ff - 1'b1;
               col_nx  = (col_ff == '0) ? COLW'(COLS - 1) : col_ff - 1'b1;
               wr_hit  = 1'b1;
               wr_log  = AW'(cursor_ff - 1'b1);
               wr_cell = {attr, tcw_pkg::CH_SPACE};
            end
         end
         tcw_pkg::CH_LF: begin
            cur_nx = cursor_ff - CW'(col_ff) + CW'(COLS);
            col_nx = '0;
         end
         tcw_pkg::CH_CR: begin
            cur_nx = cursor_ff - CW'(col_ff);
            col_nx = '0;
         end
         default: begin
            cur_nx = cursor_ff + 1'b1;
            col_nx = (col_ff == COLW'(COLS - 1)) ? '0 : col_ff + 1'b1;
            wr_hit = 1'b1;
         end
      endcase
   end

   // Passing the last cell scrolls: the cursor moves up one row.
   assign need_scroll = (cur_nx >= CW'(SIZE));
   assign cur_fin     = need_scroll ? cur_nx - CW'(COLS) : cur_nx;

   // Logical to physical cell index through the rotating row offset.
   assign wr_sum  = {1'b0, wr_log} + {1'b0, top_off_ff};
   assign wr_phys = (wr_sum >= SIZE_X) ? AW'(wr_sum - SIZE_X) : AW'(wr_sum);

   assign rd_in_range = (32'(req_addr_ff) < 32'(SIZE));
   assign rd_log      = AW'(req_addr_ff);
   assign rd_sum      = {1'b0, rd_log} + {1'b0, top_off_ff};
   assign rd_phys     = (rd_sum >= SIZE_X) ? AW'(rd_sum - SIZE_X) : AW'(rd_sum);

   // A scroll blanks the old top row, which then becomes the bottom row.
   assign scr_addr = top_off_ff + AW'(scr_cnt_ff);
   assign top_sum  = {1'b0, top_off_ff} + COLS_X;
   assign top_nx   = (top_sum == SIZE_X) ? '0 : AW'(top_sum);

   // Store write port selection.
   always_comb begin
      we = 1'b0;
      wa = clr_cnt_ff;
      wd = tcw_pkg::BLANK_CELL;
      priority if (cmd.clr_step) begin
         we = 1'b1;
      end else if (cmd.scroll_step) begin
         we = 1'b1;
         wa = scr_addr;
      end else if (cmd.exec_write && wr_hit) begin
         we = 1'b1;
         wa = wr_phys;
         wd = wr_cell;
      end else begin
         we = 1'b0;
      end
   end

   // Screen store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[rd_phys];
   end

   // Cursor, row offset and sweep counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff  <= '0;
         col_ff     <= '0;
         top_off_ff <= '0;
         clr_cnt_ff <= '0;
         scr_cnt_ff <= '0;
      end else begin
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.exec_write) begin
            cursor_ff <= cur_fin;
            col_ff    <= col_nx;
         end
         if (cmd.scroll_step) begin
            if (status.scroll_last) begin
               scr_cnt_ff <= '0;
               top_off_ff <= top_nx;
            end else begin
               scr_cnt_ff <= scr_cnt_ff + 1'b1;
            end
         end
      end
   end

   // Request latch and response register.
   always_ff @(posedge clock) begin
      in_range_ff <= rd_in_range;
      if (cmd.load_req) begin
         req_func_ff <= req_func;
         req_code_ff <= req_char_code;
         req_addr_ff <= req_cell_addr;
      end
      if (cmd.load_rsp) begin
         rsp_cursor_ff <= tcw_pkg::addr_type'(cursor_ff);
         rsp_cell_ff   <= (status.is_read && in_range_ff) ? rd_data_ff : '0;
      end
   end

   assign status.is_read     = (req_func_ff == tcw_pkg::FUNC_READ);
   assign status.need_scroll = need_scroll;
   assign status.clr_last    = (clr_cnt_ff == AW'(SIZE - 1));
   assign status.scroll_last = (scr_cnt_ff == COLW'(COLS - 1));

   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_cell_value = rsp_cell_ff;

endmodule

`default_nettype wire

>>> design/tcw_controller.sv
// Controller of the text console writer: sequences clearing, request execution,
// scrolling and the response handshake. Depends on tcw_pkg.
`default_nettype none

module tcw_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire tcw_pkg::status_type status,
   output tcw_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Commands decoded from the state.
   always_comb begin
      cmd             = '0;
      cmd.clr_step    = (state_ff == ST_CLEAR);
      cmd.load_req    = (state_ff == ST_IDLE) && req_valid;
      cmd.exec_write  = (state_ff == ST_EXEC) && !status.is_read;
      cmd.scroll_step = (state_ff == ST_SCROLL);
      cmd.load_rsp    = (state_ff == ST_DONE) && rsp_free;
   end

   // State and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new response may replace the one accepted in the same cycle.
         if ((state_ff == ST_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clr_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (!status.is_read && status.need_scroll) begin
                  state_ff <= ST_SCROLL;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_SCROLL: begin
               if (status.scroll_last) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> design/tcw_checker.sv
// Port-level checks for the text console writer, attached by a bind statement.
// Depends on tcw_pkg and on the ports of text_console_writer.
`default_nettype none

module tcw_checker #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire tcw_pkg::addr_type rsp_cursor_pos,
   input wire tcw_pkg::cell_type rsp_cell_value
);

   // A stalled response stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_cursor_pos) && $stable(rsp_cell_value))
      else $error("response payload changed while stalled");

   // Requests are handled one at a time: no acceptance in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // The reported cursor always lies inside the screen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_pos) < 32'(ROWS * COLS)))
      else $error("cursor outside the screen");

endmodule

bind text_console_writer tcw_checker #(
   .ROWS (ROWS),
   .COLS (COLS)
) u_tcw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cursor_pos (rsp_cursor_pos),
   .rsp_cell_value (rsp_cell_value)
);

`default_nettype wire
